// ----- rtl/ecg_qrs_rr_metrics_assert.svh -----
// assertion macros for the qrs detector checker
// depends on clk and rst_n being visible where the macros are used
`ifndef ECG_QRS_RR_METRICS_ASSERT_SVH
`define ECG_QRS_RR_METRICS_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define ECG_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("ecg_qrs_rr_metrics: same-cycle check failed");

// condition holds in the cycle after the trigger
`define ECG_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("ecg_qrs_rr_metrics: next-cycle check failed");

`endif

// ----- rtl/ecg_qrs_pkg.sv -----
// shared types and constants for the qrs detector and rr metrics block
// no dependencies
`timescale 1ns / 1ps

package ecg_qrs_pkg;

    localparam int unsigned MAX_DET_DEF = 100;
    localparam int unsigned AMP_W       = 16;
    localparam int unsigned TS_W        = 32;
    localparam int unsigned RR_W        = 16;
    localparam int unsigned SUM_W       = 23;
    localparam int unsigned THR_W       = 15;
    localparam int unsigned WARM_W      = 12;
    localparam int unsigned IDIV_W      = 4;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 15;
    localparam int unsigned DIV_W       = 32;
    localparam int unsigned DIVR_W      = 16;
    localparam int unsigned DIV_CW      = $clog2(DIV_W + 1);
    localparam int unsigned RATE_NUM    = 60000;

    localparam logic [THR_W-1:0]  THR_RST   = THR_W'(150);
    localparam logic [WARM_W-1:0] WARM_RST  = WARM_W'(10);
    localparam logic [IDIV_W-1:0] IDIV_RST  = IDIV_W'(5);
    localparam logic [WARM_W-1:0] SIDX_SAT  = {WARM_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QRS_THRESHOLD = 2'd0,
        CFG_WARMUP        = 2'd1,
        CFG_IRR_DIVISOR   = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_RUN,
        S_RATE,
        S_RATE_WAIT,
        S_MEAN,
        S_MEAN_WAIT,
        S_WALK,
        S_VAR,
        S_VAR_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [AMP_W-1:0] amplitude;
        logic [TS_W-1:0]  timestamp_ms;
        logic             end_of_batch;
    } in_item_t;

    typedef struct packed {
        logic            qrs_flag;
        logic            metrics_valid;
        logic [RR_W-1:0] heart_rate_bpm;
        logic [RR_W-1:0] rr_interval_ms;
        logic [RR_W-1:0] rr_variance;
        logic            arrhythmia;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

endpackage

// ----- rtl/ecg_qrs_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on ecg_qrs_pkg
`timescale 1ns / 1ps

module ecg_qrs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ecg_qrs_pkg::div_req_t         req,
    output logic                          done,
    output logic [ecg_qrs_pkg::DIV_W-1:0] quotient
);
    import ecg_qrs_pkg::*;

    logic [DIVR_W:0]   rem_reg,  rem_next;
    logic [DIV_W-1:0]  quo_reg,  quo_next;
    logic [DIVR_W-1:0] dvs_reg,  dvs_next;
    logic [DIV_CW-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVR_W:0]   shifted;
    logic              fits;

    // one shift and subtract step
    always_comb
    begin
        shifted   = {rem_reg[DIVR_W-1:0], quo_reg[DIV_W-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = DIV_CW'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CW'(1);
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/ecg_qrs_mem.sv -----
// rr interval store, one write and one registered read port
// depends on ecg_qrs_pkg
`timescale 1ns / 1ps

module ecg_qrs_mem #(
    parameter int unsigned DEPTH = ecg_qrs_pkg::MAX_DET_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [ecg_qrs_pkg::RR_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [ecg_qrs_pkg::RR_W-1:0] rd_data
);
    import ecg_qrs_pkg::*;

    logic [RR_W-1:0] mem [DEPTH];
    logic [RR_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/ecg_qrs_rr_metrics.sv -----
// Derivative-threshold QRS detector with RR interval metrics. A new ordinary
// sample is taken every cycle while the result register drains. An
// end-of-batch sample whose batch recorded no interval is also answered
// directly, without a batch close. Otherwise the batch close runs on the shared
// one-bit-per-cycle divider, issuing one division each for rate, mean and
// variance, and a walk of the interval memory at one entry per cycle through
// the registered memory read, the squared difference and the accumulator. The
// close holds the input off from the end-of-batch transfer until the result is
// issued; with a single interval only the rate division runs, and a zero last
// interval skips the rate division. Configuration writes are taken every
// cycle.
// depends on ecg_qrs_pkg, ecg_qrs_div and ecg_qrs_mem
`timescale 1ns / 1ps

module ecg_qrs_rr_metrics #(
    parameter int unsigned MAX_DETECTIONS = ecg_qrs_pkg::MAX_DET_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ecg_qrs_pkg::in_item_t              in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ecg_qrs_pkg::out_item_t             out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ecg_qrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ecg_qrs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ecg_qrs_pkg::*;

    localparam int unsigned CW = $clog2(MAX_DETECTIONS + 1);
    localparam int unsigned AW = $clog2(MAX_DETECTIONS);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DETECTIONS);

    state_t state_reg, state_next;

    logic [THR_W-1:0]  thr_reg,   thr_next;
    logic [WARM_W-1:0] warm_reg,  warm_next;
    logic [IDIV_W-1:0] idiv_reg,  idiv_next;

    logic [AMP_W-1:0]  prev_amp_reg, prev_amp_next;
    logic [WARM_W-1:0] sidx_reg,     sidx_next;
    logic [TS_W-1:0]   last_ts_reg,  last_ts_next;
    logic [CW-1:0]     qrs_cnt_reg,  qrs_cnt_next;
    logic [CW-1:0]     rr_cnt_reg,   rr_cnt_next;
    logic [SUM_W-1:0]  rr_sum_reg,   rr_sum_next;
    logic              irr_reg,      irr_next;
    logic [RR_W-1:0]   last_rr_reg,  last_rr_next;
    logic              flag_reg,     flag_next;

    logic [RR_W-1:0]   h_rate_reg, h_rate_next;
    logic [RR_W-1:0]   h_rr_reg,   h_rr_next;
    logic [RR_W-1:0]   h_var_reg,  h_var_next;
    logic              h_arr_reg,  h_arr_next;

    logic [RR_W-1:0]   mean_reg,   mean_next;
    logic [CW-1:0]     issue_reg,  issue_next;
    logic              v1_reg,     v1_next;
    logic              v2_reg,     v2_next;
    logic [DIV_W-1:0]  sq_reg,     sq_next;
    logic [DIV_W-1:0]  acc_reg,    acc_next;

    out_item_t         out_reg,    out_next;
    logic              ov_reg,     ov_next;

    logic              accept;
    logic [AMP_W-1:0]  diff;
    logic [AMP_W-1:0]  mag;
    logic              det;
    logic              take_qrs;
    logic              rec;
    logic [RR_W-1:0]   rr_new;
    logic [RR_W-1:0]   dchg;
    logic [IDIV_W-1:0] kdiv;
    logic [RR_W+IDIV_W-1:0] prod;
    logic              irr_hit;
    logic [RR_W-1:0]   rd_diff;
    logic              walk_done;
    logic              few;
    logic [RR_W-1:0]   emit_var;

    div_req_t          div_req;
    logic              div_done;
    logic [DIV_W-1:0]  div_q;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [RR_W-1:0]   rd_data;

    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign few       = rr_cnt_reg < CW'(2);
    assign walk_done = (issue_reg == rr_cnt_reg) && !v1_reg && !v2_reg;

    // per-sample slope test and interval bookkeeping
    always_comb
    begin
        diff     = in_data.amplitude - prev_amp_reg;
        mag      = diff[AMP_W-1] ? (~diff + AMP_W'(1)) : diff;
        det      = (sidx_reg >= warm_reg) && (mag > {1'b0, thr_reg});
        take_qrs = det && (qrs_cnt_reg < MAX_CNT);
        rec      = take_qrs && (qrs_cnt_reg != '0) && (rr_cnt_reg < MAX_CNT);
        rr_new   = in_data.timestamp_ms[RR_W-1:0] - last_ts_reg[RR_W-1:0];
        dchg     = (rr_new >= last_rr_reg) ? (rr_new - last_rr_reg)
                                           : (last_rr_reg - rr_new);
        kdiv     = (idiv_reg == '0) ? IDIV_W'(1) : idiv_reg;
        // change > before / k is the same test as change * k > before
        prod     = dchg * kdiv;
        irr_hit  = (rr_cnt_reg != '0) && (prod > {{IDIV_W{1'b0}}, last_rr_reg});
        rd_diff  = (rd_data >= mean_reg) ? (rd_data - mean_reg) : (mean_reg - rd_data);
        emit_var = few ? '0 : h_var_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_RUN:
            begin
                if (accept && in_data.end_of_batch && (rec || (rr_cnt_reg != '0)))
                begin
                    state_next = S_RATE;
                end
            end
            S_RATE:
            begin
                if (last_rr_reg != '0)
                begin
                    state_next = S_RATE_WAIT;
                end
                else
                begin
                    state_next = few ? S_EMIT : S_MEAN;
                end
            end
            S_RATE_WAIT:
            begin
                if (div_done)
                begin
                    state_next = few ? S_EMIT : S_MEAN;
                end
            end
            S_MEAN:      state_next = S_MEAN_WAIT;
            S_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_done)
                begin
                    state_next = S_VAR;
                end
            end
            S_VAR:       state_next = S_VAR_WAIT;
            S_VAR_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:      state_next = S_RUN;
            default:     state_next = S_RUN;
        endcase
    end

    // sequencer outputs: handshake, divider requests and memory reads
    always_comb
    begin
        in_ready         = (state_reg == S_RUN) && (!ov_reg || out_ready);
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(RATE_NUM);
        div_req.divisor  = last_rr_reg;
        rd_en            = 1'b0;
        rd_addr          = issue_reg[AW-1:0];
        case (state_reg)
            S_RATE:
            begin
                div_req.start = last_rr_reg != '0;
            end
            S_MEAN:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(rr_sum_reg);
                div_req.divisor  = DIVR_W'(rr_cnt_reg);
            end
            S_WALK:
            begin
                rd_en = issue_reg != rr_cnt_reg;
            end
            S_VAR:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = acc_reg;
                div_req.divisor  = DIVR_W'(rr_cnt_reg);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // datapath register updates
    always_comb
    begin
        thr_next      = thr_reg;
        warm_next     = warm_reg;
        idiv_next     = idiv_reg;
        prev_amp_next = prev_amp_reg;
        sidx_next     = sidx_reg;
        last_ts_next  = last_ts_reg;
        qrs_cnt_next  = qrs_cnt_reg;
        rr_cnt_next   = rr_cnt_reg;
        rr_sum_next   = rr_sum_reg;
        irr_next      = irr_reg;
        last_rr_next  = last_rr_reg;
        flag_next     = flag_reg;
        h_rate_next   = h_rate_reg;
        h_rr_next     = h_rr_reg;
        h_var_next    = h_var_reg;
        h_arr_next    = h_arr_reg;
        mean_next     = mean_reg;
        issue_next    = issue_reg;
        v1_next       = 1'b0;
        v2_next       = v1_reg;
        sq_next       = {{(DIV_W-RR_W){1'b0}}, rd_diff} * {{(DIV_W-RR_W){1'b0}}, rd_diff};
        acc_next      = acc_reg;
        out_next      = out_reg;
        ov_next       = ov_reg && !out_ready;

        // configuration writes
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_QRS_THRESHOLD: thr_next  = cfg_data[THR_W-1:0];
                CFG_WARMUP:        warm_next = cfg_data[WARM_W-1:0];
                CFG_IRR_DIVISOR:   idiv_next = cfg_data[IDIV_W-1:0];
                default:           thr_next  = thr_reg;
            endcase
        end

        // sample transfer
        if (accept)
        begin
            prev_amp_next = in_data.amplitude;
            if (sidx_reg != SIDX_SAT)
            begin
                sidx_next = sidx_reg + WARM_W'(1);
            end
            if (take_qrs)
            begin
                qrs_cnt_next = qrs_cnt_reg + CW'(1);
                last_ts_next = in_data.timestamp_ms;
            end
            if (rec)
            begin
                rr_cnt_next  = rr_cnt_reg + CW'(1);
                rr_sum_next  = rr_sum_reg + SUM_W'(rr_new);
                last_rr_next = rr_new;
                if (irr_hit)
                begin
                    irr_next = 1'b1;
                end
            end
            flag_next = det;
            if (!in_data.end_of_batch)
            begin
                ov_next  = 1'b1;
                out_next = '{qrs_flag: det, metrics_valid: 1'b0, heart_rate_bpm: '0,
                             rr_interval_ms: '0, rr_variance: '0, arrhythmia: 1'b0};
            end
            else if (!rec && (rr_cnt_reg == '0))
            begin
                // batch without intervals: held metrics go out unchanged
                ov_next      = 1'b1;
                out_next     = '{qrs_flag: det, metrics_valid: 1'b1,
                                 heart_rate_bpm: h_rate_reg, rr_interval_ms: h_rr_reg,
                                 rr_variance: h_var_reg, arrhythmia: h_arr_reg};
                sidx_next    = '0;
                qrs_cnt_next = '0;
                rr_sum_next  = '0;
                irr_next     = 1'b0;
            end
        end

        // batch close
        case (state_reg)
            S_RATE:
            begin
                if (last_rr_reg == '0)
                begin
                    h_rate_next = '0;
                end
            end
            S_RATE_WAIT:
            begin
                if (div_done)
                begin
                    h_rate_next = div_q[RR_W-1:0];
                end
            end
            S_MEAN_WAIT:
            begin
                mean_next  = div_q[RR_W-1:0];
                issue_next = '0;
                acc_next   = '0;
            end
            S_WALK:
            begin
                if (issue_reg != rr_cnt_reg)
                begin
                    issue_next = issue_reg + CW'(1);
                    v1_next    = 1'b1;
                end
                if (v2_reg)
                begin
                    acc_next = acc_reg + sq_reg;
                end
            end
            S_VAR_WAIT:
            begin
                if (div_done)
                begin
                    h_var_next = div_q[RR_W-1:0];
                end
            end
            S_EMIT:
            begin
                h_rr_next    = last_rr_reg;
                h_var_next   = emit_var;
                h_arr_next   = (rr_cnt_reg >= CW'(3)) && irr_reg;
                ov_next      = 1'b1;
                out_next     = '{qrs_flag: flag_reg, metrics_valid: 1'b1,
                                 heart_rate_bpm: h_rate_reg, rr_interval_ms: last_rr_reg,
                                 rr_variance: emit_var,
                                 arrhythmia: (rr_cnt_reg >= CW'(3)) && irr_reg};
                sidx_next    = '0;
                qrs_cnt_next = '0;
                rr_cnt_next  = '0;
                rr_sum_next  = '0;
                irr_next     = 1'b0;
            end
            default:
            begin
                mean_next = mean_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_RUN;
            thr_reg      <= THR_RST;
            warm_reg     <= WARM_RST;
            idiv_reg     <= IDIV_RST;
            prev_amp_reg <= '0;
            sidx_reg     <= '0;
            qrs_cnt_reg  <= '0;
            rr_cnt_reg   <= '0;
            rr_sum_reg   <= '0;
            irr_reg      <= 1'b0;
            last_rr_reg  <= '0;
            h_rate_reg   <= '0;
            h_rr_reg     <= '0;
            h_var_reg    <= '0;
            h_arr_reg    <= 1'b0;
            issue_reg    <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            thr_reg      <= thr_next;
            warm_reg     <= warm_next;
            idiv_reg     <= idiv_next;
            prev_amp_reg <= prev_amp_next;
            sidx_reg     <= sidx_next;
            qrs_cnt_reg  <= qrs_cnt_next;
            rr_cnt_reg   <= rr_cnt_next;
            rr_sum_reg   <= rr_sum_next;
            irr_reg      <= irr_next;
            last_rr_reg  <= last_rr_next;
            h_rate_reg   <= h_rate_next;
            h_rr_reg     <= h_rr_next;
            h_var_reg    <= h_var_next;
            h_arr_reg    <= h_arr_next;
            issue_reg    <= issue_next;
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            ov_reg       <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        last_ts_reg <= last_ts_next;
        flag_reg    <= flag_next;
        mean_reg    <= mean_next;
        sq_reg      <= sq_next;
        acc_reg     <= acc_next;
        out_reg     <= out_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    ecg_qrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    ecg_qrs_mem #(
        .DEPTH (MAX_DETECTIONS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (accept && rec),
        .wr_addr (rr_cnt_reg[AW-1:0]),
        .wr_data (rr_new),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ----- rtl/ecg_qrs_chk.sv -----
// port-level checker for the qrs detector, bound to the top level
// depends on ecg_qrs_pkg and ecg_qrs_rr_metrics_assert.svh
`timescale 1ns / 1ps
`include "ecg_qrs_rr_metrics_assert.svh"

module ecg_qrs_chk (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input ecg_qrs_pkg::in_item_t  in_data,
    input logic                   out_valid,
    input logic                   out_ready,
    input ecg_qrs_pkg::out_item_t out_data
);
    import ecg_qrs_pkg::*;

    // a stalled result holds
    `ECG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    // no new sample while a result is stuck
    `ECG_ASSERT_NOW(a_no_take_stalled, out_valid && !out_ready, !in_ready)
    // a mid-batch sample gives its result in the next cycle
    `ECG_ASSERT_NEXT(a_mid_result, in_valid && in_ready && !in_data.end_of_batch, out_valid && !out_data.metrics_valid)
    // metric fields are zero outside end-of-batch results
    `ECG_ASSERT_NOW(a_metrics_zero, out_valid && !out_data.metrics_valid, out_data.heart_rate_bpm == '0 && out_data.rr_interval_ms == '0 && out_data.rr_variance == '0 && !out_data.arrhythmia)
    // rate never exceeds one beat per millisecond
    `ECG_ASSERT_NOW(a_rate_range, out_valid, out_data.heart_rate_bpm <= RR_W'(RATE_NUM))

endmodule

bind ecg_qrs_rr_metrics ecg_qrs_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
